@@ design/nsv_pkg.sv @@
// Shared constants, types and helper functions for the NMEA sentence validator.
package nsv_pkg;

    // Line buffer sizing
    localparam int LINE_CAPACITY = 128;
    localparam int CNT_W         = $clog2(LINE_CAPACITY);
    localparam int LEN_W         = 7;
    localparam int MIN_LEN       = 9;

    // Character codes
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_STAR   = 8'h2A;

    // Pattern matcher: matched prefix length, four means the whole tag was seen
    localparam int         PAT_LEN     = 4;
    localparam logic [2:0] MATCH_FOUND = 3'd4;

    typedef logic [7:0] t_pat [PAT_LEN];

    localparam t_pat PAT_GGA = '{8'h47, 8'h47, 8'h41, 8'h2C};
    localparam t_pat PAT_RMC = '{8'h52, 8'h4D, 8'h43, 8'h2C};
    localparam t_pat PAT_VTG = '{8'h56, 8'h54, 8'h47, 8'h2C};

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_GGA   = 2'd1,
        KIND_RMC   = 2'd2,
        KIND_VTG   = 2'd3
    } t_kind;

    // Byte held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_byte_stage;

    // One finished line summary
    typedef struct packed {
        logic             sentence_valid;
        t_kind            sentence_kind;
        logic [LEN_W-1:0] line_length;
        logic [7:0]       computed_checksum;
    } t_result;

    // Longest prefix of pat that ends the matched text after appending c
    function automatic logic [2:0] match_next(input t_pat pat, input logic [2:0] k,
                                              input logic [7:0] c);
        logic [2:0] res;
        logic       ok;
        int         idx;
        res = '0;
        if (k >= MATCH_FOUND) begin
            res = MATCH_FOUND;
        end else begin
            for (int jj = 1; jj <= PAT_LEN; jj++) begin
                if (jj <= int'(k) + 1) begin
                    ok = (pat[jj-1] == c);
                    for (int ii = 0; ii < PAT_LEN - 1; ii++) begin
                        if (ii + 1 < jj) begin
                            idx = int'(k) - jj + 1 + ii;
                            ok  = ok && (pat[ii] == pat[idx[1:0]]);
                        end
                    end
                    if (ok) begin
                        res = jj[2:0];
                    end
                end
            end
        end
        return res;
    endfunction

    // Decode one hex digit: {hit, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        case (c) inside
            [8'h30:8'h39]: res = {1'b1, 4'(c - 8'h30)};
            [8'h61:8'h66]: res = {1'b1, 4'(c - 8'h57)};
            [8'h41:8'h46]: res = {1'b1, 4'(c - 8'h37)};
            default:       res = '0;
        endcase
        return res;
    endfunction

endpackage

@@ design/nsv_if.sv @@
// Valid/ready channel interfaces for received bytes and line results.
interface nsv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsv_result_if;
    logic       valid;
    logic       ready;
    logic       sentence_valid;
    logic [1:0] sentence_kind;
    logic [6:0] line_length;
    logic [7:0] computed_checksum;

    modport source (output valid, output sentence_valid, output sentence_kind,
                    output line_length, output computed_checksum, input ready);
    modport sink   (input valid, input sentence_valid, input sentence_kind,
                    input line_length, input computed_checksum, output ready);
endinterface

@@ design/nsv_in_stage.sv @@
// Input register: captures one received byte per beat.
module nsv_in_stage
    import nsv_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    nsv_byte_if.sink     i_byte,
    input  logic         i_take,
    output t_byte_stage  o_stage
);

    logic       r_valid;
    logic [7:0] r_data;

    // Accept when empty or when the held byte leaves this cycle
    assign i_byte.ready = !r_valid || i_take;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_valid <= i_byte.valid;
        end
    end

    // Load payload on each accepted beat
    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_data <= i_byte.rx_byte;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.data  = r_data;

endmodule

@@ design/nsv_line_track.sv @@
// Per-line state: length, leading dollar, checksum, tag matchers and the line summary.
module nsv_line_track
    import nsv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_byte_stage i_stage,
    input  logic        i_out_free,
    output logic        o_take,
    output logic        o_res_load,
    output t_result     o_res
);

    logic [CNT_W-1:0] r_count,    n_count;
    logic             r_dollar,   n_dollar;
    logic [7:0]       r_xor,      n_xor;
    logic             r_star,     n_star;
    logic [1:0]       r_after,    n_after;
    logic [7:0]       r_rx_sum,   n_rx_sum;
    logic             r_hex_end,  n_hex_end;
    logic [2:0]       r_gga,      n_gga;
    logic [2:0]       r_rmc,      n_rmc;
    logic [2:0]       r_vtg,      n_vtg;

    logic [7:0] c;
    logic       is_cr;
    logic       is_lf;
    logic       full;
    logic [4:0] hex;

    assign c     = i_stage.data;
    assign is_cr = (c == CHR_CR);
    assign is_lf = (c == CHR_LF);
    assign full  = (r_count >= CNT_W'(LINE_CAPACITY - 1));
    assign hex   = hex_decode(c);

    // A line feed needs room in the output register; other bytes always advance
    assign o_take = i_stage.valid && (!is_lf || i_out_free);

    // Build the summary of the line held so far
    always_comb begin
        o_res.sentence_valid = (r_count >= CNT_W'(MIN_LEN)) && r_dollar && r_star
                               && (r_after == 2'd2) && (r_xor == r_rx_sum);
        if (r_gga == MATCH_FOUND) begin
            o_res.sentence_kind = KIND_GGA;
        end else if (r_rmc == MATCH_FOUND) begin
            o_res.sentence_kind = KIND_RMC;
        end else if (r_vtg == MATCH_FOUND) begin
            o_res.sentence_kind = KIND_VTG;
        end else begin
            o_res.sentence_kind = KIND_OTHER;
        end
        o_res.line_length       = LEN_W'(r_count);
        o_res.computed_checksum = r_xor;
    end

    // Advance line state by one byte
    always_comb begin
        n_count   = r_count;
        n_dollar  = r_dollar;
        n_xor     = r_xor;
        n_star    = r_star;
        n_after   = r_after;
        n_rx_sum  = r_rx_sum;
        n_hex_end = r_hex_end;
        n_gga     = r_gga;
        n_rmc     = r_rmc;
        n_vtg     = r_vtg;
        o_res_load = 1'b0;
        if (o_take && !is_cr) begin
            if (is_lf || full) begin
                // End of line or overflow: drop back to an empty line
                o_res_load = is_lf;
                n_count   = '0;
                n_dollar  = 1'b0;
                n_xor     = '0;
                n_star    = 1'b0;
                n_after   = '0;
                n_rx_sum  = '0;
                n_hex_end = 1'b0;
                n_gga     = '0;
                n_rmc     = '0;
                n_vtg     = '0;
            end else begin
                if (r_count == '0) begin
                    n_dollar = (c == CHR_DOLLAR);
                end else if (!r_star) begin
                    if (c == CHR_STAR) begin
                        n_star = 1'b1;
                    end else begin
                        n_xor = r_xor ^ c;
                    end
                end else begin
                    if (r_after != 2'd2) begin
                        n_after = r_after + 2'd1;
                    end
                    if (!r_hex_end) begin
                        if (hex[4]) begin
                            n_rx_sum = {r_rx_sum[3:0], hex[3:0]};
                        end else begin
                            n_hex_end = 1'b1;
                        end
                    end
                end
                n_gga   = match_next(PAT_GGA, r_gga, c);
                n_rmc   = match_next(PAT_RMC, r_rmc, c);
                n_vtg   = match_next(PAT_VTG, r_vtg, c);
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    // Update line registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dollar  <= 1'b0;
            r_xor     <= '0;
            r_star    <= 1'b0;
            r_after   <= '0;
            r_rx_sum  <= '0;
            r_hex_end <= 1'b0;
            r_gga     <= '0;
            r_rmc     <= '0;
            r_vtg     <= '0;
        end else begin
            r_count   <= n_count;
            r_dollar  <= n_dollar;
            r_xor     <= n_xor;
            r_star    <= n_star;
            r_after   <= n_after;
            r_rx_sum  <= n_rx_sum;
            r_hex_end <= n_hex_end;
            r_gga     <= n_gga;
            r_rmc     <= n_rmc;
            r_vtg     <= n_vtg;
        end
    end

endmodule

@@ design/nsv_out_stage.sv @@
// Result register: holds one line summary until the sink takes the beat.
module nsv_out_stage
    import nsv_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_result       i_res,
    output logic          o_free,
    nsv_result_if.source  o_result
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_result.ready;

    // Hold valid until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Load payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_result.valid             = r_valid;
    assign o_result.sentence_valid    = r_res.sentence_valid;
    assign o_result.sentence_kind     = r_res.sentence_kind;
    assign o_result.line_length       = r_res.line_length;
    assign o_result.computed_checksum = r_res.computed_checksum;

endmodule

@@ design/nmea_sentence_validator.sv @@
// Top level of the NMEA sentence validator.
//
//  channel   | dir | modport | payload
//  ----------+-----+---------+-----------------------------------------------
//  i_byte    | in  | sink    | rx_byte[7:0]
//  o_result  | out | source  | sentence_valid, sentence_kind[1:0],
//            |     |         | line_length[6:0], computed_checksum[7:0]
//
//  One byte per cycle sustained unless a line feed waits (see below); a byte that does not
//  wait updates the line state at the edge after the one that loads it into the input register.
//  A line feed's result is valid from the edge at which the line state takes the line feed.
//  A line feed waits in the input register while the result register is full
//  and not taken; other bytes never wait on the output side.
//  Reset (synchronous, active low) empties both registers and the line state.
module nmea_sentence_validator
    import nsv_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    nsv_byte_if.sink      i_byte,
    nsv_result_if.source  o_result
);

    t_byte_stage stage;
    logic        take;
    logic        res_load;
    t_result     res;
    logic        out_free;

    nsv_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_take  (take),
        .o_stage (stage)
    );

    nsv_line_track u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stage    (stage),
        .i_out_free (out_free),
        .o_take     (take),
        .o_res_load (res_load),
        .o_res      (res)
    );

    nsv_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_load),
        .i_res    (res),
        .o_free   (out_free),
        .o_result (o_result)
    );

    // A result comes only from a held line feed
    a_res_from_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> (stage.valid && stage.data == CHR_LF))
        else $error("result loaded without a line feed");

    // A loaded result is presented in the next cycle
    a_res_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |=> o_result.valid)
        else $error("loaded result not presented");

    // A held byte that does not advance stays unchanged
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage.valid && !take) |=> (stage.valid && $stable(stage.data)))
        else $error("stalled byte lost or changed");

endmodule

@@ verif/nmea_sentence_validator_tb.sv @@
// Self-checking testbench for the NMEA sentence validator: byte stream in, line results out.
`timescale 1ns / 100ps

module nmea_sentence_validator_tb
    import nsv_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 500;
    localparam int MARK_BASE    = 256;   // pending entries at or above this are drain marks
    localparam int TAIL_CYCLES  = 8;

    // Idle pattern of one stimulus phase
    typedef enum int {
        PACE_FREE,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } t_pace;

    // Shapes of generated sentences
    typedef enum int {
        SHAPE_GOOD,
        SHAPE_BAD_SUM,
        SHAPE_SHORT_HEX,
        SHAPE_NO_DOLLAR,
        SHAPE_EXTRA_HEX,
        SHAPE_FULL_LINE
    } t_shape;

    logic i_clk;
    logic i_rst_n;

    nsv_byte_if   byte_ch ();
    nsv_result_if result_ch ();

    nmea_sentence_validator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (result_ch)
    );

    // Stimulus bytes waiting to be sent, and line summaries waiting to come out
    int      pending_bytes[$];
    t_result expected_lines[$];
    logic [7:0] line_text[$];

    t_pace pace;
    int    cycle_count;
    int    fail_count;
    int    bytes_sent;
    int    lines_checked;
    int    valid_lines;
    int    kind_seen[4];

    // Line tracker state
    logic [6:0] ln_count;
    logic       ln_dollar;
    logic [7:0] ln_xor;
    logic       ln_star;
    logic [1:0] ln_after;
    logic [7:0] ln_rx_sum;
    logic       ln_hex_done;
    logic [2:0] ln_gga;
    logic [2:0] ln_rmc;
    logic [2:0] ln_vtg;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic clear_line_state();
        ln_count    = '0;
        ln_dollar   = 1'b0;
        ln_xor      = '0;
        ln_star     = 1'b0;
        ln_after    = '0;
        ln_rx_sum   = '0;
        ln_hex_done = 1'b0;
        ln_gga      = '0;
        ln_rmc      = '0;
        ln_vtg      = '0;
    endtask

    // Longest tag prefix that ends the text seen so far plus c
    function automatic logic [2:0] tag_progress(input t_pat tag, input logic [2:0] k,
                                                input logic [7:0] c);
        bit hit;
        if (k >= MATCH_FOUND) return MATCH_FOUND;
        for (int j = int'(k) + 1; j > 0; j--) begin
            hit = (tag[j-1] == c);
            for (int i = 0; i + 1 < j; i++) begin
                if (tag[i] != tag[int'(k) - (j - 1) + i]) hit = 0;
            end
            if (hit) return 3'(j);
        end
        return 3'd0;
    endfunction

    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    // Advance the line tracker by one accepted byte; a line feed queues its summary
    task automatic track_line_byte(input logic [7:0] c);
        t_result r;
        int      h;
        if (c == CHR_CR) return;
        if (c == CHR_LF) begin
            r.sentence_valid = (int'(ln_count) >= MIN_LEN) && ln_dollar && ln_star &&
                               (ln_after >= 2'd2) && (ln_xor == ln_rx_sum);
            if (ln_gga == MATCH_FOUND)      r.sentence_kind = KIND_GGA;
            else if (ln_rmc == MATCH_FOUND) r.sentence_kind = KIND_RMC;
            else if (ln_vtg == MATCH_FOUND) r.sentence_kind = KIND_VTG;
            else                            r.sentence_kind = KIND_OTHER;
            r.line_length       = ln_count;
            r.computed_checksum = ln_xor;
            expected_lines.push_back(r);
            clear_line_state();
            return;
        end
        // Drop the whole line on overflow
        if (int'(ln_count) >= LINE_CAPACITY - 1) begin
            clear_line_state();
            return;
        end
        if (ln_count == 0) begin
            ln_dollar = (c == CHR_DOLLAR);
        end else if (!ln_star) begin
            if (c == CHR_STAR) ln_star = 1'b1;
            else               ln_xor  = ln_xor ^ c;
        end else begin
            if (ln_after < 2'd2) ln_after = ln_after + 2'd1;
            if (!ln_hex_done) begin
                h = hex_digit_value(c);
                if (h < 0) ln_hex_done = 1'b1;
                else       ln_rx_sum   = {ln_rx_sum[3:0], 4'(h)};
            end
        end
        ln_gga   = tag_progress(PAT_GGA, ln_gga, c);
        ln_rmc   = tag_progress(PAT_RMC, ln_rmc, c);
        ln_vtg   = tag_progress(PAT_VTG, ln_vtg, c);
        ln_count = ln_count + 7'd1;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) pending_bytes.push_back(int'(8'(s[i])));
    endtask

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++) line_text.push_back(8'(s[i]));
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return (lower ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] pick_char(input string alphabet);
        return 8'(alphabet[$urandom_range(alphabet.len() - 1)]);
    endfunction

    // End a line with LF, CR LF or a doubled CR followed by LF
    task automatic close_line();
        int roll;
        roll = $urandom_range(9);
        if (roll < 7)       push_text("\r\n");
        else if (roll < 9)  push_text("\n");
        else                push_text("\r\r\n");
    endtask

    // Talker, tag and comma-separated fields of a sentence body
    task automatic build_body();
        int nfields;
        int flen;
        line_text = {};
        case ($urandom_range(3))
            0: append_text("GP");
            1: append_text("GN");
            2: append_text("GL");
            default: begin
                line_text.push_back(pick_char("ABCDEFGHIJKLMNOPQRSTUVWXYZ"));
                line_text.push_back(pick_char("ABCDEFGHIJKLMNOPQRSTUVWXYZ"));
            end
        endcase
        case ($urandom_range(3))
            0: append_text("GGA");
            1: append_text("RMC");
            2: append_text("VTG");
            default: begin
                for (int i = 0; i < 3; i++) line_text.push_back(pick_char("GARMCVTX"));
            end
        endcase
        nfields = $urandom_range(10);
        for (int f = 0; f < nfields; f++) begin
            line_text.push_back(",");
            // Sometimes bury a second tag to exercise the kind priority
            if ($urandom_range(19) == 0) begin
                case ($urandom_range(2))
                    0: append_text("GGA,");
                    1: append_text("RMC,");
                    default: append_text("VTG,");
                endcase
            end
            flen = $urandom_range(6);
            for (int i = 0; i < flen; i++) begin
                case ($urandom_range(9))
                    6: line_text.push_back(".");
                    7: line_text.push_back(pick_char("NSEW"));
                    8: line_text.push_back(pick_char("AV"));
                    9: line_text.push_back("-");
                    default: line_text.push_back(8'h30 + 8'($urandom_range(9)));
                endcase
            end
        end
        if (nfields == 0) line_text.push_back(",");
    endtask

    // Frame a body as a sentence, bending it according to shape
    task automatic add_sentence(input t_shape shape);
        logic [7:0] sum;
        int         pad_to;
        bit         lower;
        build_body();
        if (shape == SHAPE_FULL_LINE) begin
            // Full line is body plus four: spans 125 to 129 characters
            pad_to = $urandom_range(121, 125);
            while (line_text.size() < pad_to) line_text.push_back(8'h30 + 8'($urandom_range(9)));
            while (line_text.size() > pad_to) void'(line_text.pop_back());
        end
        sum = '0;
        foreach (line_text[i]) sum = sum ^ line_text[i];
        lower = 1'($urandom_range(1));
        if (shape == SHAPE_NO_DOLLAR) push_text("!");
        else                          pending_bytes.push_back(int'(CHR_DOLLAR));
        foreach (line_text[i]) pending_bytes.push_back(int'(line_text[i]));
        pending_bytes.push_back(int'(CHR_STAR));
        if (shape == SHAPE_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
        if (shape == SHAPE_EXTRA_HEX) pending_bytes.push_back(int'(hex_char(4'($urandom), lower)));
        if (shape != SHAPE_SHORT_HEX) pending_bytes.push_back(int'(hex_char(sum[7:4], lower)));
        pending_bytes.push_back(int'(hex_char(sum[3:0], lower)));
        if (shape != SHAPE_FULL_LINE && $urandom_range(9) == 0) push_text(",A");
        close_line();
    endtask

    // One random line: mostly sentences, the rest noise and broken lines
    task automatic add_random_line();
        int roll;
        int n;
        roll = $urandom_range(99);
        if (roll < 60)       add_sentence(SHAPE_GOOD);
        else if (roll < 65)  add_sentence(SHAPE_BAD_SUM);
        else if (roll < 68)  add_sentence(SHAPE_SHORT_HEX);
        else if (roll < 71)  add_sentence(SHAPE_NO_DOLLAR);
        else if (roll < 75)  add_sentence(SHAPE_EXTRA_HEX);
        else if (roll < 79)  add_sentence(SHAPE_FULL_LINE);
        else if (roll < 85) begin
            n = $urandom_range(20);
            for (int i = 0; i < n; i++) pending_bytes.push_back($urandom_range(255));
            push_text("\n");
        end else if (roll < 91) begin
            // Tag letters and stars only, to stress the matchers
            pending_bytes.push_back(int'(CHR_DOLLAR));
            n = $urandom_range(5, 30);
            for (int i = 0; i < n; i++) pending_bytes.push_back(int'(pick_char("GARMCVT,*")));
            close_line();
        end else if (roll < 95) begin
            n = $urandom_range(128, 160);
            for (int i = 0; i < n; i++) pending_bytes.push_back($urandom_range(32, 126));
            push_text("\n");
        end else if (roll < 98) begin
            close_line();
        end else begin
            // Sentence cut off before its checksum
            build_body();
            pending_bytes.push_back(int'(CHR_DOLLAR));
            n = $urandom_range(line_text.size());
            for (int i = 0; i < n; i++) pending_bytes.push_back(int'(line_text[i]));
            close_line();
        end
    endtask

    // Drive bytes from the pending queue; hold at drain marks until all lines are out
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else if (!byte_ch.valid || byte_ch.ready) begin
            if (pending_bytes.size() == 0) begin
                byte_ch.valid <= 1'b0;
            end else if (pending_bytes[0] >= MARK_BASE) begin
                byte_ch.valid <= 1'b0;
                if (!byte_ch.valid && expected_lines.size() == 0 &&
                    !(result_ch.valid && result_ch.ready)) begin
                    pace <= t_pace'(pending_bytes.pop_front() - MARK_BASE);
                end
            end else if ((pace == PACE_SEND_IDLE && $urandom_range(99) < 80) ||
                         (pace == PACE_BOTH && $urandom_range(99) < 23)) begin
                byte_ch.valid <= 1'b0;
            end else begin
                byte_ch.valid   <= 1'b1;
                byte_ch.rx_byte <= 8'(pending_bytes.pop_front());
            end
        end
    end

    // Stall the result side according to the phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else if ((pace == PACE_RECV_STALL && $urandom_range(99) < 80) ||
                     (pace == PACE_BOTH && $urandom_range(99) < 23)) begin
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // Track accepted bytes and check each result beat against the oldest line
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (byte_ch.valid && byte_ch.ready) begin
                track_line_byte(byte_ch.rx_byte);
                bytes_sent++;
            end
            if (result_ch.valid && result_ch.ready) begin
                if (expected_lines.size() == 0) begin
                    $error("result beat with no line pending");
                    fail_count++;
                end else begin
                    want = expected_lines.pop_front();
                    lines_checked++;
                    if (want.sentence_valid) valid_lines++;
                    kind_seen[int'(want.sentence_kind)]++;
                    if (result_ch.sentence_valid !== want.sentence_valid) begin
                        $error("sentence_valid: expected %0d, got %0d",
                               want.sentence_valid, result_ch.sentence_valid);
                        fail_count++;
                    end
                    if (result_ch.sentence_kind !== want.sentence_kind) begin
                        $error("sentence_kind: expected %0d, got %0d",
                               want.sentence_kind, result_ch.sentence_kind);
                        fail_count++;
                    end
                    if (result_ch.line_length !== want.line_length) begin
                        $error("line_length: expected %0d, got %0d",
                               want.line_length, result_ch.line_length);
                        fail_count++;
                    end
                    if (result_ch.computed_checksum !== want.computed_checksum) begin
                        $error("computed_checksum: expected 0x%02h, got 0x%02h",
                               want.computed_checksum, result_ch.computed_checksum);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("nmea_sentence_validator_tb failed");
            $finish;
        end
    end

    initial begin
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = '0;
        result_ch.ready = 1'b0;
        i_rst_n         = 1'b0;
        pace            = PACE_FREE;
        cycle_count     = 0;
        fail_count      = 0;
        bytes_sent      = 0;
        lines_checked   = 0;
        valid_lines     = 0;
        kind_seen       = '{default: 0};
        clear_line_state();

        // Directed: empty line, star first with zero and all-ones bytes,
        // shortest valid sentence with lowercase hex, star with no digits
        push_text("\n");
        push_text("*");
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        push_text("\r\n");
        push_text("$GGA,0*5d\r\n");
        push_text("$RMC,1*Q\n");

        // Random phases, each behind a drain mark
        for (int p = 0; p < 4; p++) begin
            int mark;
            pending_bytes.push_back(MARK_BASE + p);
            mark = pending_bytes.size();
            while (pending_bytes.size() < mark + PHASE_BYTES) add_random_line();
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || byte_ch.valid) @(posedge i_clk);
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes over four idle phases; checked %0d lines, %0d valid",
                 bytes_sent, lines_checked, valid_lines);
        $display("line kinds seen: other %0d, GGA %0d, RMC %0d, VTG %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        if (fail_count == 0 && expected_lines.size() == 0) begin
            $display("nmea_sentence_validator_tb passed");
        end else begin
            $display("nmea_sentence_validator_tb failed");
        end
        $finish;
    end

endmodule
